FILE: sv/pffc_pkg.sv
// ----------------------------------------------------------------------------
// pffc_pkg - shared types and constants of the PID feed-forward controller
// Fixed-point formats, microcode word layout, opcode and register codes.
// ----------------------------------------------------------------------------
package pffc_pkg;

    // Q16.16 data, unsigned Q8.16 time step
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int DT_W      = 8 + FRAC_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = DATA_W + FRAC_W + 4;
    localparam int DIV_W     = DATA_W + 1 + FRAC_W;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int OP_W      = 2;
    localparam int CLAMP_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    // stream word layouts
    localparam int S_TDATA_W = 3 * DATA_W + DT_W;
    localparam int M_TDATA_W = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t VAL_HI = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t VAL_LO = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(VAL_HI);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(VAL_LO);

    // quotient magnitude limits for the positive and negative rate
    localparam logic [DIV_W-1:0] Q_POS_MAX =
        {{(DIV_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic [DIV_W-1:0] Q_NEG_MAX =
        {{(DIV_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

    // operation codes; the unused code behaves as clear
    localparam logic [OP_W-1:0] OP_UPDATE   = 2'd0;
    localparam logic [OP_W-1:0] OP_SUPPLIED = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    // clamp status codes
    localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_MAX  = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_MIN  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd5;

    // microprogram addresses
    typedef enum logic [STEP_W-1:0] {
        ST_IDLE, ST_DISPATCH, ST_CHKSUP, ST_DIFF, ST_DIVSTEP, ST_DIVEND,
        ST_MUL_EDT, ST_TSAT, ST_MUL_KIT, ST_INTEG, ST_MUL_KPE, ST_MUL_KDD,
        ST_MUL_KFR, ST_ACC, ST_DONE, ST_CLEAR
    } step_t;

    typedef enum logic [2:0] {
        COND_NEVER, COND_ALWAYS, COND_START, COND_CLEAR, COND_SUPPLIED,
        COND_CNT_ZERO, COND_OUT_FREE
    } cond_t;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_EDT, MUL_KIT, MUL_KPE, MUL_KDD, MUL_KFR
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        DP_NONE, DP_DIV_INIT, DP_DIV_STEP, DP_RATE, DP_TSAT, DP_INTEG,
        DP_CLEAR, DP_DONE
    } dp_op_t;

    typedef struct packed {
        mul_sel_t mul;
        acc_op_t  acc;
        dp_op_t   op;
    } dp_ctrl_t;

    typedef struct packed {
        cond_t    cond;
        step_t    target;
        logic     hold;
        logic     cnt_load;
        dp_ctrl_t ctrl;
    } ucode_t;

    typedef struct packed {
        logic is_clear;
        logic is_supplied;
    } dp_flags_t;

    typedef struct packed {
        logic idle;
        logic push;
    } seq_stat_t;

    typedef struct packed {
        data_t prop_gain;
        data_t integ_gain;
        data_t deriv_gain;
        data_t ff_gain;
        data_t out_min;
        data_t out_max;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        data_t           err_value;
        data_t           err_rate;
        data_t           ff_reference;
        logic [DT_W-1:0] time_step;
    } item_t;

    typedef struct packed {
        data_t              drive;
        logic [CLAMP_W-1:0] clamped;
        data_t              integ_value;
    } result_t;

    // saturate a wide signed value to the data range
    function automatic data_t sat_data(input logic signed [PROD_W-1:0] v);
        data_t r;
        if (v > SAT_HI) begin
            r = VAL_HI;
        end else if (v < SAT_LO) begin
            r = VAL_LO;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/pffc_sequencer.sv
// ----------------------------------------------------------------------------
// pffc_sequencer - microprogram store, step counter and loop counter
// One control word per step; conditional jumps, hold-in-place and a
// loop counter for the bit-serial divide.
// ----------------------------------------------------------------------------
module pffc_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 out_free,
    input  pffc_pkg::dp_flags_t  flags,
    output pffc_pkg::dp_ctrl_t   ctrl,
    output pffc_pkg::seq_stat_t  stat
);
    import pffc_pkg::*;

    step_t            pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ucode_t           uw;
    logic             cond_hit;

    function automatic ucode_t mk(input cond_t c, input step_t tgt, input logic hold,
                                  input logic cl, input mul_sel_t m, input acc_op_t a,
                                  input dp_op_t o);
        ucode_t w;
        w.cond      = c;
        w.target    = tgt;
        w.hold      = hold;
        w.cnt_load  = cl;
        w.ctrl.mul  = m;
        w.ctrl.acc  = a;
        w.ctrl.op   = o;
        return w;
    endfunction

    // microprogram
    always_comb begin
        unique case (pc_reg)
            ST_IDLE:     uw = mk(COND_START, ST_DISPATCH, 1'b1, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_NONE);
            ST_DISPATCH: uw = mk(COND_CLEAR, ST_CLEAR, 1'b0, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_NONE);
            ST_CHKSUP:   uw = mk(COND_SUPPLIED, ST_MUL_EDT, 1'b0, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_NONE);
            ST_DIFF:     uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b1,
                                 MUL_NONE, ACC_HOLD, DP_DIV_INIT);
            ST_DIVSTEP:  uw = mk(COND_CNT_ZERO, ST_DIVEND, 1'b1, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_DIV_STEP);
            ST_DIVEND:   uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_RATE);
            ST_MUL_EDT:  uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_EDT, ACC_HOLD, DP_NONE);
            ST_TSAT:     uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_TSAT);
            ST_MUL_KIT:  uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_KIT, ACC_HOLD, DP_NONE);
            ST_INTEG:    uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_INTEG);
            ST_MUL_KPE:  uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_KPE, ACC_LOAD, DP_NONE);
            ST_MUL_KDD:  uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_KDD, ACC_ADD, DP_NONE);
            ST_MUL_KFR:  uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_KFR, ACC_ADD, DP_NONE);
            ST_ACC:      uw = mk(COND_NEVER, ST_IDLE, 1'b0, 1'b0,
                                 MUL_NONE, ACC_ADD, DP_NONE);
            ST_DONE:     uw = mk(COND_OUT_FREE, ST_IDLE, 1'b1, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_DONE);
            ST_CLEAR:    uw = mk(COND_ALWAYS, ST_DONE, 1'b0, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_CLEAR);
            default:     uw = mk(COND_ALWAYS, ST_IDLE, 1'b0, 1'b0,
                                 MUL_NONE, ACC_HOLD, DP_NONE);
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_START:    cond_hit = start;
            COND_CLEAR:    cond_hit = flags.is_clear;
            COND_SUPPLIED: cond_hit = flags.is_supplied;
            COND_CNT_ZERO: cond_hit = (cnt_reg == '0);
            COND_OUT_FREE: cond_hit = out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            pc_next = uw.target;
        end else if (uw.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = step_t'(pc_reg + STEP_W'(1));
        end

        if (uw.cnt_load) begin
            cnt_next = CNT_W'(DIV_W - 1);
        end else if ((uw.cond == COND_CNT_ZERO) && (cnt_reg != '0)) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end else begin
            cnt_next = cnt_reg;
        end

        ctrl      = uw.ctrl;
        stat.idle = (pc_reg == ST_IDLE);
        stat.push = (uw.ctrl.op == DP_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/pffc_datapath.sv
// ----------------------------------------------------------------------------
// pffc_datapath - operand registers, shared multiplier, restoring divider,
// sum accumulator and output clamp, driven by the microcode control word.
// ----------------------------------------------------------------------------
module pffc_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  pffc_pkg::item_t     item,
    input  pffc_pkg::cfg_t      cfg,
    input  pffc_pkg::dp_ctrl_t  ctrl,
    output pffc_pkg::dp_flags_t flags,
    output pffc_pkg::result_t   result
);
    import pffc_pkg::*;

    logic [OP_W-1:0]           op_reg;
    data_t                     e_reg, de_reg, ref_reg, t_reg;
    logic [DT_W-1:0]           dt_reg;
    data_t                     last_err_reg, integ_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [DIV_W-1:0]          num_reg;
    logic [DT_W-1:0]           rem_reg;
    logic                      neg_reg, zero_reg;

    logic                      is_clear;
    logic [DATA_W:0]           diff_u, diff_mag;
    logic [DT_W:0]             trial, trial_sub, dt_ext;
    logic                      q_bit;
    logic [DT_W-1:0]           rem_next;
    data_t                     rate_next;
    data_t                     mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p, prod_sh, integ_sum;
    logic signed [ACC_W-1:0]   clip, max_e, min_e;
    logic [CLAMP_W-1:0]        flag;

    assign is_clear          = (op_reg != OP_UPDATE) && (op_reg != OP_SUPPLIED);
    assign flags.is_clear    = is_clear;
    assign flags.is_supplied = (op_reg == OP_SUPPLIED);

    // error difference at full precision, magnitude for the divider
    assign diff_u   = {e_reg[DATA_W-1], e_reg} - {last_err_reg[DATA_W-1], last_err_reg};
    assign diff_mag = diff_u[DATA_W] ? (~diff_u + 1'b1) : diff_u;

    // one restoring divide step; a zero divisor yields an all-ones quotient
    assign dt_ext    = {1'b0, dt_reg};
    assign trial     = {rem_reg, num_reg[DIV_W-1]};
    assign trial_sub = trial - dt_ext;
    assign q_bit     = (trial >= dt_ext);
    assign rem_next  = q_bit ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];

    // signed, saturated rate from quotient magnitude
    always_comb begin
        if (zero_reg) begin
            rate_next = '0;
        end else if (!neg_reg) begin
            rate_next = (num_reg > Q_POS_MAX) ? VAL_HI : data_t'(num_reg[DATA_W-1:0]);
        end else begin
            rate_next = (num_reg > Q_NEG_MAX) ? VAL_LO
                                              : data_t'(~num_reg[DATA_W-1:0] + 1'b1);
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (ctrl.mul)
            MUL_EDT: begin
                mul_a = e_reg;
                mul_b = data_t'({{(DATA_W-DT_W){1'b0}}, dt_reg});
            end
            MUL_KIT: begin
                mul_a = cfg.integ_gain;
                mul_b = t_reg;
            end
            MUL_KPE: begin
                mul_a = cfg.prop_gain;
                mul_b = e_reg;
            end
            MUL_KDD: begin
                mul_a = cfg.deriv_gain;
                mul_b = de_reg;
            end
            MUL_KFR: begin
                mul_a = cfg.ff_gain;
                mul_b = ref_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_sh   = prod_reg >>> FRAC_W;   // floor by 2^FRAC_W
    assign integ_sum = PROD_W'(integ_reg) + prod_sh;

    // clamp: max first, then min
    assign max_e = ACC_W'(cfg.out_max);
    assign min_e = ACC_W'(cfg.out_min);
    always_comb begin
        clip = acc_reg;
        flag = CLAMP_NONE;
        if (clip > max_e) begin
            clip = max_e;
            flag = CLAMP_MAX;
        end
        if (clip < min_e) begin
            clip = min_e;
            flag = CLAMP_MIN;
        end
        if (is_clear) begin
            result.drive       = '0;
            result.clamped     = CLAMP_NONE;
            result.integ_value = '0;
        end else begin
            result.drive       = clip[DATA_W-1:0];
            result.clamped     = flag;
            result.integ_value = integ_reg;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (load) begin
            op_reg  <= item.operation;
            e_reg   <= item.err_value;
            de_reg  <= item.err_rate;
            ref_reg <= item.ff_reference;
            dt_reg  <= item.time_step;
        end
        if (ctrl.mul != MUL_NONE) begin
            prod_reg <= mul_p;
        end
        unique case (ctrl.acc)
            ACC_LOAD: acc_reg <= ACC_W'(integ_reg);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_sh);
            default:  ;
        endcase
        unique case (ctrl.op)
            DP_DIV_INIT: begin
                num_reg  <= {diff_mag, {FRAC_W{1'b0}}};
                rem_reg  <= '0;
                neg_reg  <= diff_u[DATA_W];
                zero_reg <= (diff_u == '0);
            end
            DP_DIV_STEP: begin
                num_reg <= {num_reg[DIV_W-2:0], q_bit};
                rem_reg <= rem_next;
            end
            DP_RATE: de_reg <= rate_next;
            DP_TSAT: t_reg  <= sat_data(prod_sh);
            default: ;
        endcase
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            integ_reg    <= '0;
        end else begin
            unique case (ctrl.op)
                DP_INTEG: integ_reg    <= sat_data(integ_sum);
                DP_CLEAR: integ_reg    <= '0;
                DP_DONE:  last_err_reg <= is_clear ? '0 : e_reg;
                default:  ;
            endcase
        end
    end

endmodule

FILE: sv/pid_feed_forward_controller.sv
// ----------------------------------------------------------------------------
// pid_feed_forward_controller - PID step with feed-forward, signed Q16.16
// Microcoded controller: one shared 32x32 multiplier, a bit-serial divider
// for the computed error rate, saturating integral and clamped output.
// ----------------------------------------------------------------------------
// One word in gives one word out. The block works on one word at a time:
// s_tready is high only while the microsequencer sits in its idle step.
// An update with computed rate (operation 0) first runs the restoring
// divider, which yields one quotient bit per clock; an update with
// supplied rate (operation 1) skips the divider, and its five products
// share the one multiplier; a clear (operation 2 or 3) skips both. The
// result is registered and held until taken; a result that is not taken
// holds the sequencer in its final step. Configuration writes are
// accepted in every cycle (cfg_ready is always high) and should be issued
// only while the block is idle.
// ----------------------------------------------------------------------------
module pid_feed_forward_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // err_value[31:0], err_rate[63:32], ff_reference[95:64], time_step[119:96]
    input  logic [pffc_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[1:0]
    input  logic [pffc_pkg::OP_W-1:0]         s_tuser,
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // drive[31:0], integ_value[63:32]
    output logic [pffc_pkg::M_TDATA_W-1:0]    m_tdata,
    // clamped[1:0]
    output logic [pffc_pkg::CLAMP_W-1:0]      m_tuser,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pffc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pffc_pkg::DATA_W-1:0]       cfg_data
);
    import pffc_pkg::*;

    cfg_t                cfg_reg;
    item_t               item;
    result_t             result;
    dp_ctrl_t            ctrl;
    dp_flags_t           flags;
    seq_stat_t           stat;
    logic                accept;
    logic                out_free;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [CLAMP_W-1:0]  m_tuser_reg;

    assign s_tready  = stat.idle;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // unpack input word
    assign item.operation    = s_tuser;
    assign item.err_value    = data_t'(s_tdata[DATA_W-1:0]);
    assign item.err_rate     = data_t'(s_tdata[2*DATA_W-1:DATA_W]);
    assign item.ff_reference = data_t'(s_tdata[3*DATA_W-1:2*DATA_W]);
    assign item.time_step    = s_tdata[3*DATA_W+DT_W-1:3*DATA_W];

    // gain and limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain  <= '0;
            cfg_reg.integ_gain <= '0;
            cfg_reg.deriv_gain <= '0;
            cfg_reg.ff_gain    <= '0;
            cfg_reg.out_min    <= VAL_LO;
            cfg_reg.out_max    <= VAL_HI;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= data_t'(cfg_data);
                REG_INTEG_GAIN: cfg_reg.integ_gain <= data_t'(cfg_data);
                REG_DERIV_GAIN: cfg_reg.deriv_gain <= data_t'(cfg_data);
                REG_FF_GAIN:    cfg_reg.ff_gain    <= data_t'(cfg_data);
                REG_OUT_MIN:    cfg_reg.out_min    <= data_t'(cfg_data);
                REG_OUT_MAX:    cfg_reg.out_max    <= data_t'(cfg_data);
                default:        ;   // unmapped index: write dropped
            endcase
        end
    end

    // output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    pffc_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .out_free (out_free),
        .flags    (flags),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    pffc_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .ctrl     (ctrl),
        .flags    (flags),
        .result   (result)
    );

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (stat.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.push) begin
            m_tdata_reg <= {result.integ_value, result.drive};
            m_tuser_reg <= result.clamped;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: sv/pffc_checker.sv
// ----------------------------------------------------------------------------
// pffc_checker - port-level checks for the PID feed-forward controller
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pffc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pffc_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [pffc_pkg::CLAMP_W-1:0]      m_tuser
);

    // one word at a time: an accepted word drops ready
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("s_tready high right after an accepted word");

    // a result needs several steps; it never shows the cycle after accept
    a_no_instant_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready)
    ) else $error("result word appeared one cycle after accept");

    // stalled result word holds
    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    ) else $error("stalled result word changed or dropped");

endmodule

bind pid_feed_forward_controller pffc_checker u_pffc_checker (.*);
